### design/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // result queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH   = 4;
    localparam int PUSH_W     = $clog2(MAX_PUSH + 1);

    localparam logic [1:0] QUAD_LAST = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_LENGTH  = 2'd1,
        STAT_PADDING = 2'd2,
        STAT_INVALID = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_status;
        status_t    status;
        logic       last_result;
    } result_t;

    // bit 6 set marks a character outside the alphabet
    typedef logic [6:0] sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            s = {1'b0, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            s = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B)
        begin
            s = 7'd62;
        end
        else if (c == 8'h2F)
        begin
            s = 7'd63;
        end
        return s;
    endfunction

    function automatic result_t byte_result(input logic [7:0] b);
        result_t r;
        r.data_byte   = b;
        r.is_status   = 1'b0;
        r.status      = STAT_OK;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic result_t status_result(input status_t st);
        result_t r;
        r.data_byte   = 8'd0;
        r.is_status   = 1'b1;
        r.status      = st;
        r.last_result = 1'b1;
        return r;
    endfunction

endpackage

### design/b64d_char_if.sv
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

### design/b64d_res_if.sv
interface b64d_res_if
    import b64d_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_status;
    status_t    status;
    logic       last_result;

    modport source (output valid, output data_byte, output is_status, output status,
                    output last_result, input ready);
    modport sink   (input valid, input data_byte, input is_status, input status,
                    input last_result, output ready);
endinterface

### design/base64_decoder.sv
// base64 decoder: one character beat accepted per cycle while the result queue has room
// results of a character enter the registered result queue when its beat is taken and leave it in order
// a completed quad queues up to three bytes, and a string's last character adds the status beat, in the same cycle;
// the result queue drains one beat per cycle while results.ready is high and input stalls when it lacks room for four
// reset: asynchronous active low, clears quad position, error, padding flag and the queue
module base64_decoder
    import b64d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    b64d_char_if.sink        chars,
    b64d_res_if.source       results
);

    logic [7:0]        held_reg [3];
    logic [1:0]        pos_reg;
    logic [1:0]        pos_next;
    status_t           err_reg;
    status_t           err_next;
    logic              pad_reg;
    logic              pad_next;

    logic              take;
    logic              room;
    logic [PUSH_W-1:0] push_cnt;
    result_t           push_data [MAX_PUSH];
    result_t           pop_data;

    sextet_t           s0, s1, s2, s3;
    logic [7:0]        b0, b1, b2;
    logic [1:0]        pos_q;
    status_t           err_q;
    logic              pad_q;
    logic [PUSH_W-1:0] n;

    assign chars.ready = room;
    assign take        = chars.valid && room;

    always_comb
    begin
        s0 = sextet_of(held_reg[0]);
        s1 = sextet_of(held_reg[1]);
        s2 = sextet_of(held_reg[2]);
        s3 = sextet_of(chars.char_in);
        b0 = {s0[5:0], s1[5:4]};
        b1 = {s1[3:0], s2[5:2]};
        b2 = {s2[1:0], s3[5:0]};

        for (int k = 0; k < MAX_PUSH; k++)
        begin
            push_data[k] = '0;
        end
        n        = '0;
        err_q    = err_reg;
        pad_q    = pad_reg;
        pos_q    = pos_reg + 2'd1;
        pos_next = pos_reg;
        err_next = err_reg;
        pad_next = pad_reg;

        if (take)
        begin
            if (pos_reg == QUAD_LAST && err_reg == STAT_OK && !pad_reg)
            begin
                priority if (held_reg[0] == PAD_CHAR || held_reg[1] == PAD_CHAR)
                begin
                    err_q = STAT_PADDING;
                end
                else if (held_reg[2] == PAD_CHAR)
                begin
                    if (s0[6] || s1[6])
                    begin
                        err_q = STAT_INVALID;
                    end
                    else
                    begin
                        pad_q        = 1'b1;
                        push_data[0] = byte_result(b0);
                        n            = PUSH_W'(1);
                    end
                end
                else if (chars.char_in == PAD_CHAR)
                begin
                    if (s0[6] || s1[6] || s2[6])
                    begin
                        err_q = STAT_INVALID;
                    end
                    else
                    begin
                        pad_q        = 1'b1;
                        push_data[0] = byte_result(b0);
                        push_data[1] = byte_result(b1);
                        n            = PUSH_W'(2);
                    end
                end
                else if (s0[6] || s1[6] || s2[6] || s3[6])
                begin
                    err_q = STAT_INVALID;
                end
                else
                begin
                    push_data[0] = byte_result(b0);
                    push_data[1] = byte_result(b1);
                    push_data[2] = byte_result(b2);
                    n            = PUSH_W'(3);
                end
            end

            if (chars.is_last)
            begin
                // length error wins over anything found in the quads
                push_data[n[1:0]] = status_result((pos_q != 2'd0) ? STAT_LENGTH : err_q);
                n        = n + PUSH_W'(1);
                pos_next = 2'd0;
                err_next = STAT_OK;
                pad_next = 1'b0;
            end
            else
            begin
                pos_next = pos_q;
                err_next = err_q;
                pad_next = pad_q;
            end
        end
        push_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            err_reg <= STAT_OK;
            pad_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            err_reg <= err_next;
            pad_reg <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pos_reg != QUAD_LAST)
        begin
            held_reg[pos_reg] <= chars.char_in;
        end
    end

    b64d_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .room      (room),
        .pop_valid (results.valid),
        .pop_ready (results.ready),
        .pop_data  (pop_data)
    );

    assign results.data_byte   = pop_data.data_byte;
    assign results.is_status   = pop_data.is_status;
    assign results.status      = pop_data.status;
    assign results.last_result = pop_data.last_result;

endmodule

### design/b64d_fifo.sv
module b64d_fifo
    import b64d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PUSH_W-1:0] push_cnt,
    input  result_t           push_data [MAX_PUSH],
    output logic              room,
    output logic              pop_valid,
    input  logic              pop_ready,
    output result_t           pop_data
);

    result_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    // room for the largest group one character can produce
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_PUSH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[head_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        head_next  = head_reg + PTR_W'(pop);
        tail_next  = tail_reg + PTR_W'(push_cnt);
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PUSH; k++)
        begin
            if (PUSH_W'(k) < push_cnt)
            begin
                mem_reg[tail_reg + PTR_W'(k)] <= push_data[k];
            end
        end
    end

endmodule

### verif/base64_decoder_tb.sv
module base64_decoder_tb;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DIRECTED_CHARS = 25;
    localparam int RANDOM_CHARS   = 155;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    b64d_char_if chars_if ();
    b64d_res_if  results_if ();

    base64_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    always #5 clk = ~clk;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    char_beat_t char_q[$];
    result_t    owed[$];
    logic [7:0] text_buf[$];

    // decoder state as the block should hold it
    logic [1:0] quad_pos;
    logic [7:0] held[3];
    status_t    str_err;
    logic       pad_done;

    int         cycle;
    int         n_queued;
    int         n_accepted;
    int         n_strings;
    int         n_bytes;
    int         status_seen[4];
    int         mismatches;
    char_beat_t beat;
    result_t    want;

    task automatic report(input string what);
        if (mismatches < 50)
        begin
            $display("mismatch at cycle %0d: %s", cycle, what);
        end
        mismatches++;
    endtask

    // bit 6 flags a character outside the alphabet
    function automatic logic [6:0] alpha_index(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (alphabet[i] == c)
            begin
                return 7'(i);
            end
        end
        return 7'h40;
    endfunction

    function automatic result_t data_beat(input logic [7:0] b);
        result_t r;
        r.data_byte   = b;
        r.is_status   = 1'b0;
        r.status      = STAT_OK;
        r.last_result = 1'b0;
        return r;
    endfunction

    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [6:0] s0, s1, s2, s3;
        logic [7:0] b0, b1, b2;
        result_t    fin;
        if (quad_pos != QUAD_LAST)
        begin
            held[quad_pos] = c;
        end
        else if (str_err == STAT_OK && !pad_done)
        begin
            s0 = alpha_index(held[0]);
            s1 = alpha_index(held[1]);
            s2 = alpha_index(held[2]);
            s3 = alpha_index(c);
            b0 = {s0[5:0], s1[5:4]};
            b1 = {s1[3:0], s2[5:2]};
            b2 = {s2[1:0], s3[5:0]};
            if (held[0] == PAD_CHAR || held[1] == PAD_CHAR)
            begin
                str_err = STAT_PADDING;
            end
            else if (held[2] == PAD_CHAR)
            begin
                // one byte; fourth character is don't-care
                if (s0[6] || s1[6])
                begin
                    str_err = STAT_INVALID;
                end
                else
                begin
                    pad_done = 1'b1;
                    owed.insert(owed.size(), data_beat(b0));
                end
            end
            else if (c == PAD_CHAR)
            begin
                if (s0[6] || s1[6] || s2[6])
                begin
                    str_err = STAT_INVALID;
                end
                else
                begin
                    pad_done = 1'b1;
                    owed.insert(owed.size(), data_beat(b0));
                    owed.insert(owed.size(), data_beat(b1));
                end
            end
            else if (s0[6] || s1[6] || s2[6] || s3[6])
            begin
                str_err = STAT_INVALID;
            end
            else
            begin
                owed.insert(owed.size(), data_beat(b0));
                owed.insert(owed.size(), data_beat(b1));
                owed.insert(owed.size(), data_beat(b2));
            end
        end
        quad_pos = quad_pos + 2'd1;
        if (last)
        begin
            // a ragged length wins over any earlier error
            fin.data_byte   = 8'd0;
            fin.is_status   = 1'b1;
            fin.status      = (quad_pos != 2'd0) ? STAT_LENGTH : str_err;
            fin.last_result = 1'b1;
            owed.insert(owed.size(), fin);
            quad_pos = 2'd0;
            str_err  = STAT_OK;
            pad_done = 1'b0;
        end
    endtask

    function automatic bit take_turn();
        if (n_accepted >= 80 && n_accepted < 140)
        begin
            return 1'b1;
        end
        return $urandom_range(99) >= 26;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid   <= 1'b0;
            chars_if.char_in <= 8'd0;
            chars_if.is_last <= 1'b0;
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                decode_char(chars_if.char_in, chars_if.is_last);
                n_accepted <= n_accepted + 1;
            end
            if (!chars_if.valid || chars_if.ready)
            begin
                if (char_q.size() != 0 && take_turn())
                begin
                    beat = char_q.pop_front();
                    chars_if.valid   <= 1'b1;
                    chars_if.char_in <= beat.code;
                    chars_if.is_last <= beat.last;
                end
                else
                begin
                    chars_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (owed.size() == 0)
                begin
                    report($sformatf("unexpected beat byte %02h status flag %0b",
                                     results_if.data_byte, results_if.is_status));
                end
                else
                begin
                    want = owed.pop_front();
                    if (results_if.data_byte !== want.data_byte)
                    begin
                        report($sformatf("data_byte %02h, wanted %02h",
                                         results_if.data_byte, want.data_byte));
                    end
                    if (results_if.is_status !== want.is_status)
                    begin
                        report($sformatf("is_status %0b, wanted %0b",
                                         results_if.is_status, want.is_status));
                    end
                    if (results_if.status !== want.status)
                    begin
                        report($sformatf("status %0d, wanted %0d",
                                         results_if.status, want.status));
                    end
                    if (results_if.last_result !== want.last_result)
                    begin
                        report($sformatf("last_result %0b, wanted %0b",
                                         results_if.last_result, want.last_result));
                    end
                    if (want.is_status)
                    begin
                        status_seen[want.status]++;
                    end
                    else
                    begin
                        n_bytes++;
                    end
                end
            end
            results_if.ready <= take_turn();
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still owed", cycle, owed.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.insert(text_buf.size(), s[i]);
        end
    endtask

    task automatic send_string();
        char_beat_t cb;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            cb.code = text_buf[i];
            cb.last = (i == text_buf.size() - 1);
            char_q.insert(char_q.size(), cb);
        end
        n_queued += text_buf.size();
        n_strings++;
        text_buf.delete();
    endtask

    task automatic encode_bytes(input int nbytes);
        logic [23:0] w;
        int          take;
        for (int i = 0; i < nbytes; i += 3)
        begin
            take = (nbytes - i >= 3) ? 3 : nbytes - i;
            w = {8'($urandom), 8'($urandom), 8'($urandom)};
            if (take < 3)
            begin
                w[7:0] = 8'd0;
            end
            if (take < 2)
            begin
                w[15:8] = 8'd0;
            end
            text_buf.insert(text_buf.size(), alphabet[w[23:18]]);
            text_buf.insert(text_buf.size(), alphabet[w[17:12]]);
            text_buf.insert(text_buf.size(), take > 1 ? alphabet[w[11:6]] : PAD_CHAR);
            text_buf.insert(text_buf.size(), take > 2 ? alphabet[w[5:0]] : PAD_CHAR);
        end
    endtask

    function automatic logic [7:0] noise_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            return PAD_CHAR;
        end
        if (pick < 65)
        begin
            return alphabet[$urandom_range(63)];
        end
        return 8'($urandom);
    endfunction

    // mostly proper encodings, some corrupted, a few pure noise
    task automatic random_string();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            n = $urandom_range(1, 8);
            repeat (n) text_buf.insert(text_buf.size(), noise_char());
        end
        else
        begin
            encode_bytes($urandom_range(1, 9));
            if (kind >= 60 && kind < 72)
            begin
                text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom);
            end
            else if (kind >= 72 && kind < 80)
            begin
                text_buf[$urandom_range(text_buf.size() - 1)] = PAD_CHAR;
            end
            else if (kind >= 80 && kind < 88)
            begin
                void'(text_buf.pop_back());
            end
            else if (kind >= 88)
            begin
                // trailing characters, often a whole extra quad
                n = ($urandom_range(1) == 1) ? 4 : $urandom_range(1, 5);
                repeat (n) text_buf.insert(text_buf.size(), noise_char());
            end
        end
        send_string();
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || owed.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        bit paused;
        paused           = 1'b0;
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.char_in = 8'd0;
        chars_if.is_last = 1'b0;
        results_if.ready = 1'b0;
        quad_pos         = 2'd0;
        str_err          = STAT_OK;
        pad_done         = 1'b0;
        cycle            = 0;
        n_queued         = 0;
        n_accepted       = 0;
        n_strings        = 0;
        n_bytes          = 0;
        mismatches       = 0;
        status_seen      = '{default: 0};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full quad with both symbol characters
        add_text("az+/");
        send_string();
        // two-pad quad, then a quad that must be ignored
        add_text("TQ==09AZ");
        send_string();
        // bad first character, rest of the string ignored
        text_buf.insert(text_buf.size(), 8'hFF);
        add_text("AA");
        text_buf.insert(text_buf.size(), 8'h00);
        send_string();
        // pad in second slot, but ragged length takes priority
        add_text("A=AAB");
        send_string();
        add_text("TWE=");
        send_string();

        // hold the sender until the block has emptied out
        wait_drained();

        while (n_queued < DIRECTED_CHARS + RANDOM_CHARS)
        begin
            random_string();
            if (!paused && n_queued >= DIRECTED_CHARS + RANDOM_CHARS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);

        $display("ran %0d characters in %0d strings, %0d decoded bytes checked",
                 n_accepted, n_strings, n_bytes);
        $display("final beats: ok %0d, bad length %0d, bad padding %0d, bad character %0d",
                 status_seen[STAT_OK], status_seen[STAT_LENGTH],
                 status_seen[STAT_PADDING], status_seen[STAT_INVALID]);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
design/b64d_pkg.sv
design/b64d_char_if.sv
design/b64d_res_if.sv
design/b64d_fifo.sv
design/base64_decoder.sv
verif/base64_decoder_tb.sv
